// ===== hdl/sstw_pkg.sv =====
// shared types and constants for the two-wire seven-segment display driver
// no dependencies; imported by the driver core, the line checker and the testbench
package sstw_pkg;

	localparam int TPU_W  = 10;
	localparam int WAIT_W = 13;
	localparam int VAL_W  = 14;

	localparam logic [TPU_W-1:0] TPU_RESET = 10'd16;

	// register index on the config port
	localparam logic REG_TPU = 1'b0;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_DECIMAL = 2'd1,
		OP_BRIGHT  = 2'd2
	} opcode_t;

	typedef enum logic {
		KIND_BRIGHT  = 1'b0,
		KIND_DECIMAL = 1'b1
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_S_CLKH  = 5'd1,
		PH_S_DIOH  = 5'd2,
		PH_S_WAIT  = 5'd3,
		PH_S_DIOL  = 5'd4,
		PH_B_CLKL  = 5'd5,
		PH_B_DIO   = 5'd6,
		PH_B_W1    = 5'd7,
		PH_B_CLKH  = 5'd8,
		PH_B_W2    = 5'd9,
		PH_A_CLKL  = 5'd10,
		PH_A_W1    = 5'd11,
		PH_A_CLKH  = 5'd12,
		PH_A_W2    = 5'd13,
		PH_A_CLKL2 = 5'd14,
		PH_P_CLKL  = 5'd15,
		PH_P_W1    = 5'd16,
		PH_P_DIOL  = 5'd17,
		PH_P_W2    = 5'd18,
		PH_P_CLKH  = 5'd19,
		PH_P_W3    = 5'd20,
		PH_P_DIOH  = 5'd21
	} phase_t;

	// display controller command bytes
	localparam logic [7:0] CMD_DATA = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hC0;
	localparam logic [7:0] CMD_DISP = 8'h87;
	localparam logic [7:0] SEP_BIT  = 8'h80;

	localparam logic [3:0] BRIGHT_MAX = 4'd8;

	// line timing waits in microseconds
	localparam logic [2:0] USEC_SHORT = 3'd2;
	localparam logic [2:0] USEC_BIT   = 3'd3;
	localparam logic [2:0] USEC_ACK   = 3'd5;

	// floor(v / 10) == (v * 3277) >> 15 for every 14-bit v
	localparam logic [11:0] RECIP_10 = 12'd3277;
	localparam int RECIP_SHIFT = 15;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		unique case (digit)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/seven_segment_two_wire_driver_core.sv =====
// two-wire serial driver for a four-digit seven-segment display module
// line sequencer, background digit converter, config register, output register
// depends on sstw_pkg
//
//   channel  | dir | handshake                  | contents
//   s_axis   | in  | tvalid/tready              | tuser opcode, tdata value/separator/brightness
//   m_axis   | out | tvalid/tready              | tdata line levels, busy, accepted
//   apb      | in  | psel/penable/pwrite/pready | ticks_per_usec at byte address 0
//
// a word taken at an edge has its result in the output register at that same edge;
// a new word is taken every cycle while the result is drained.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
// after a show-decimal command the digit converter works out the four digits, one per cycle,
// well before the digits go out on the line.
// reset: lines released high, sequencer idle, ticks_per_usec = 16.
module seven_segment_two_wire_driver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // value[13:0], separator[14], brightness[18:15]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // clk_level[0], dio_level[1], busy_res[2], accepted[3]
);
	import sstw_pkg::*;

	logic [TPU_W-1:0]  tpu_q;
	phase_t            phase_q, phase_d;
	logic [2:0]        bit_q, bit_d;
	logic [2:0]        byte_q, byte_d;
	logic              frame_q, frame_d;
	kind_t             kind_q, kind_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [7:0]        shift_q, shift_d;
	logic              clk_line_q, clk_line_d;
	logic              dio_line_q, dio_line_d;
	logic [7:0]        digit_q [4];

	logic              conv_run_q;
	logic [1:0]        conv_idx_q;
	logic [VAL_W-1:0]  conv_val_q;
	logic              sep_q;

	logic              m_valid_q;
	logic [7:0]        m_data_q;

	opcode_t           op;
	logic [VAL_W-1:0]  in_value;
	logic              in_sep;
	logic [3:0]        in_bright;
	logic [3:0]        bright_sat;
	logic              s_fire;
	logic              tick_go;
	logic              cmd_go;
	logic              cfg_wr;

	logic [2:0]        usec_sel;
	logic [WAIT_W-1:0] wait_target;
	logic [WAIT_W-1:0] wait_inc;
	logic              wait_done;
	logic [2:0]        byte_inc;
	logic              more_digits;
	logic              next_frame;
	logic [1:0]        rd_idx;

	logic [25:0]       conv_prod;
	logic [10:0]       conv_quot;
	logic [VAL_W-1:0]  conv_quot_x10;
	logic [3:0]        conv_digit;

	// word fields
	assign op        = opcode_t'(s_axis_tuser);
	assign in_value  = s_axis_tdata[13:0];
	assign in_sep    = s_axis_tdata[14];
	assign in_bright = s_axis_tdata[18:15];
	assign bright_sat = (in_bright > BRIGHT_MAX) ? BRIGHT_MAX : in_bright;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire  = s_axis_tvalid && s_axis_tready;
	assign tick_go = s_fire && (op == OP_TICK);
	assign cmd_go  = s_fire && (phase_q == PH_IDLE) && ((op == OP_DECIMAL) || (op == OP_BRIGHT));

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TPU);
	assign prdata = (paddr[2] == REG_TPU) ? {{(32-TPU_W){1'b0}}, tpu_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_wr) begin
			tpu_q <= pwdata[TPU_W-1:0];
		end
	end

	// wait length for the current phase
	always_comb begin
		unique case (phase_q)
			PH_B_W1, PH_B_W2: usec_sel = USEC_BIT;
			PH_A_W1:          usec_sel = USEC_ACK;
			default:          usec_sel = USEC_SHORT;
		endcase
	end

	always_comb begin
		logic [WAIT_W-1:0] raw;
		raw = WAIT_W'(tpu_q) * WAIT_W'(usec_sel);
		wait_target = (raw == '0) ? WAIT_W'(1) : raw;
	end

	assign wait_inc    = wait_q + WAIT_W'(1);
	assign wait_done   = (wait_inc >= wait_target);
	assign byte_inc    = byte_q + 3'd1;
	assign more_digits = (kind_q == KIND_DECIMAL) && frame_q &&
		(byte_inc >= 3'd1) && (byte_inc <= 3'd4);
	assign next_frame  = (kind_q == KIND_DECIMAL) && !frame_q;
	// most significant digit goes first
	assign rd_idx      = 2'(3'd4 - byte_inc);

	// next state
	always_comb begin
		phase_d = phase_q;
		if (cmd_go) begin
			phase_d = PH_S_CLKH;
		end else if (tick_go) begin
			unique case (phase_q)
				PH_S_CLKH:  phase_d = PH_S_DIOH;
				PH_S_DIOH:  phase_d = PH_S_WAIT;
				PH_S_WAIT:  phase_d = wait_done ? PH_S_DIOL : PH_S_WAIT;
				PH_S_DIOL:  phase_d = PH_B_CLKL;
				PH_B_CLKL:  phase_d = PH_B_DIO;
				PH_B_DIO:   phase_d = PH_B_W1;
				PH_B_W1:    phase_d = wait_done ? PH_B_CLKH : PH_B_W1;
				PH_B_CLKH:  phase_d = PH_B_W2;
				PH_B_W2: begin
					if (wait_done) begin
						phase_d = (bit_q == 3'd7) ? PH_A_CLKL : PH_B_CLKL;
					end
				end
				PH_A_CLKL:  phase_d = PH_A_W1;
				PH_A_W1:    phase_d = wait_done ? PH_A_CLKH : PH_A_W1;
				PH_A_CLKH:  phase_d = PH_A_W2;
				PH_A_W2:    phase_d = wait_done ? PH_A_CLKL2 : PH_A_W2;
				PH_A_CLKL2: phase_d = more_digits ? PH_B_CLKL : PH_P_CLKL;
				PH_P_CLKL:  phase_d = PH_P_W1;
				PH_P_W1:    phase_d = wait_done ? PH_P_DIOL : PH_P_W1;
				PH_P_DIOL:  phase_d = PH_P_W2;
				PH_P_W2:    phase_d = wait_done ? PH_P_CLKH : PH_P_W2;
				PH_P_CLKH:  phase_d = PH_P_W3;
				PH_P_W3:    phase_d = wait_done ? PH_P_DIOH : PH_P_W3;
				PH_P_DIOH:  phase_d = next_frame ? PH_S_CLKH : PH_IDLE;
				default:    phase_d = PH_IDLE;
			endcase
		end
	end

	// line levels and sequencer datapath
	always_comb begin
		clk_line_d = clk_line_q;
		dio_line_d = dio_line_q;
		shift_d    = shift_q;
		bit_d      = bit_q;
		byte_d     = byte_q;
		frame_d    = frame_q;
		kind_d     = kind_q;
		wait_d     = wait_q;
		if (cmd_go) begin
			bit_d   = '0;
			byte_d  = '0;
			frame_d = 1'b0;
			wait_d  = '0;
			if (op == OP_DECIMAL) begin
				kind_d  = KIND_DECIMAL;
				shift_d = CMD_DATA;
			end else begin
				kind_d  = KIND_BRIGHT;
				shift_d = CMD_DISP + 8'(bright_sat);
			end
		end else if (tick_go) begin
			unique case (phase_q)
				PH_S_CLKH, PH_A_CLKH, PH_P_CLKH: clk_line_d = 1'b1;
				PH_S_DIOH: dio_line_d = 1'b1;
				PH_S_DIOL: begin
					dio_line_d = 1'b0;
					bit_d      = '0;
				end
				PH_B_CLKL, PH_A_CLKL, PH_P_CLKL: clk_line_d = 1'b0;
				PH_B_DIO:  dio_line_d = shift_q[0];
				PH_B_CLKH: begin
					shift_d    = {1'b0, shift_q[7:1]};
					clk_line_d = 1'b1;
				end
				PH_S_WAIT, PH_B_W1, PH_A_W1, PH_A_W2, PH_P_W1, PH_P_W2, PH_P_W3: begin
					wait_d = wait_done ? '0 : wait_inc;
				end
				PH_B_W2: begin
					wait_d = wait_done ? '0 : wait_inc;
					if (wait_done) begin
						bit_d = (bit_q == 3'd7) ? 3'd0 : bit_q + 3'd1;
					end
				end
				PH_A_CLKL2: begin
					clk_line_d = 1'b0;
					byte_d     = byte_inc;
					if (more_digits) begin
						shift_d = digit_q[rd_idx];
						bit_d   = '0;
					end
				end
				PH_P_DIOL: dio_line_d = 1'b0;
				PH_P_DIOH: begin
					dio_line_d = 1'b1;
					if (next_frame) begin
						frame_d = 1'b1;
						byte_d  = '0;
						shift_d = CMD_ADDR;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_q      <= '0;
			byte_q     <= '0;
			frame_q    <= 1'b0;
			kind_q     <= KIND_BRIGHT;
			wait_q     <= '0;
			shift_q    <= '0;
			clk_line_q <= 1'b1;
			dio_line_q <= 1'b1;
		end else if (s_fire) begin
			phase_q    <= phase_d;
			bit_q      <= bit_d;
			byte_q     <= byte_d;
			frame_q    <= frame_d;
			kind_q     <= kind_d;
			wait_q     <= wait_d;
			shift_q    <= shift_d;
			clk_line_q <= clk_line_d;
			dio_line_q <= dio_line_d;
		end
	end

	// digit converter: one decimal digit per cycle, least significant first
	assign conv_prod     = 26'(conv_val_q) * 26'(RECIP_10);
	assign conv_quot     = conv_prod[25:RECIP_SHIFT];
	assign conv_quot_x10 = VAL_W'({conv_quot, 3'b000}) + VAL_W'({conv_quot, 1'b0});
	assign conv_digit    = 4'(conv_val_q - conv_quot_x10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_run_q <= 1'b0;
			conv_idx_q <= '0;
		end else if (cmd_go && (op == OP_DECIMAL)) begin
			conv_run_q <= 1'b1;
			conv_idx_q <= '0;
		end else if (conv_run_q) begin
			conv_idx_q <= conv_idx_q + 2'd1;
			if (conv_idx_q == 2'd3) begin
				conv_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_go && (op == OP_DECIMAL)) begin
			conv_val_q <= in_value;
			sep_q      <= in_sep;
		end else if (conv_run_q) begin
			conv_val_q <= VAL_W'(conv_quot);
		end
	end

	// separator dot sits on the hundreds digit
	always_ff @(posedge clk) begin
		if (conv_run_q) begin
			digit_q[conv_idx_q] <= seg_code(conv_digit) |
				(((conv_idx_q == 2'd2) && sep_q) ? SEP_BIT : 8'h00);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_data_q <= {4'b0000, cmd_go, (phase_d != PH_IDLE), dio_line_d, clk_line_d};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// digits are converted before the first one is loaded for shifting
	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_A_CLKL2) |-> !conv_run_q)
		else $error("digit conversion still running when digits are read");

	// a tick word never reports a taken command
	a_tick_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_axis_tuser == OP_TICK)) |=> !m_axis_tdata[3])
		else $error("tick word reported as accepted");

	// a taken command always leaves the sequencer busy
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
		else $error("accepted command without busy");

	// wait counter stays below the longest wait
	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q < WAIT_W'(5116))
		else $error("wait counter out of range");

endmodule

// ===== verif/sstw_line_checker.sv =====
// line-level predictor and scoreboard for the two-wire seven-segment driver
// watches the stream, result and config channels; depends on sstw_pkg
module sstw_line_checker
	import sstw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // value[13:0], separator[14], brightness[18:15]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // clk_level[0], dio_level[1], busy_res[2], accepted[3]
	output int          fail_count,
	output int          words_in_flight,
	output logic        seq_busy
);

	typedef struct packed {
		logic accepted;
		logic busy;
		logic dio;
		logic clk;
	} line_word_t;

	localparam logic [7:0] SEG_MAP [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	line_word_t levels_q [$];
	int err_count;

	phase_t           ph;
	logic [2:0]       bit_cnt;
	logic [2:0]       byte_idx;
	logic [1:0]       frame_idx;
	kind_t            kind;
	logic [15:0]      wait_cnt;
	logic [7:0]       shreg;
	logic [7:0]       digits [4];
	logic             clk_o;
	logic             dio_o;
	logic [TPU_W-1:0] tpu;

	assign fail_count = err_count;

	// counts one tick of a wait of usec microseconds, true when it runs out
	function automatic logic wait_over(input logic [2:0] usec);
		logic [15:0] target;
		target = 16'(usec) * 16'(tpu);
		if (target == 16'd0)
			target = 16'd1;
		wait_cnt = wait_cnt + 16'd1;
		if (wait_cnt >= target) begin
			wait_cnt = 16'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void step_lines();
		logic [1:0] slot;
		case (ph)
			PH_S_CLKH: begin clk_o = 1'b1; ph = PH_S_DIOH; end
			PH_S_DIOH: begin dio_o = 1'b1; ph = PH_S_WAIT; end
			PH_S_WAIT: if (wait_over(USEC_SHORT)) ph = PH_S_DIOL;
			PH_S_DIOL: begin dio_o = 1'b0; bit_cnt = 3'd0; ph = PH_B_CLKL; end
			PH_B_CLKL: begin clk_o = 1'b0; ph = PH_B_DIO; end
			PH_B_DIO:  begin dio_o = shreg[0]; ph = PH_B_W1; end
			PH_B_W1:   if (wait_over(USEC_BIT)) ph = PH_B_CLKH;
			PH_B_CLKH: begin
				shreg = shreg >> 1;
				clk_o = 1'b1;
				ph = PH_B_W2;
			end
			PH_B_W2: begin
				if (wait_over(USEC_BIT)) begin
					if (bit_cnt == 3'd7) begin
						bit_cnt = 3'd0;
						ph = PH_A_CLKL;
					end else begin
						bit_cnt = bit_cnt + 3'd1;
						ph = PH_B_CLKL;
					end
				end
			end
			PH_A_CLKL: begin clk_o = 1'b0; ph = PH_A_W1; end
			PH_A_W1:   if (wait_over(USEC_ACK)) ph = PH_A_CLKH;
			PH_A_CLKH: begin clk_o = 1'b1; ph = PH_A_W2; end
			PH_A_W2:   if (wait_over(USEC_SHORT)) ph = PH_A_CLKL2;
			PH_A_CLKL2: begin
				clk_o = 1'b0;
				byte_idx = byte_idx + 3'd1;
				// address frame carries the four digits, thousands first
				if (kind == KIND_DECIMAL && frame_idx == 2'd1 &&
						byte_idx >= 3'd1 && byte_idx <= 3'd4) begin
					slot = 2'(3'd4 - byte_idx);
					shreg = digits[slot];
					bit_cnt = 3'd0;
					ph = PH_B_CLKL;
				end else begin
					ph = PH_P_CLKL;
				end
			end
			PH_P_CLKL: begin clk_o = 1'b0; ph = PH_P_W1; end
			PH_P_W1:   if (wait_over(USEC_SHORT)) ph = PH_P_DIOL;
			PH_P_DIOL: begin dio_o = 1'b0; ph = PH_P_W2; end
			PH_P_W2:   if (wait_over(USEC_SHORT)) ph = PH_P_CLKH;
			PH_P_CLKH: begin clk_o = 1'b1; ph = PH_P_W3; end
			PH_P_W3:   if (wait_over(USEC_SHORT)) ph = PH_P_DIOH;
			PH_P_DIOH: begin
				dio_o = 1'b1;
				if (kind == KIND_DECIMAL && frame_idx == 2'd0) begin
					frame_idx = 2'd1;
					byte_idx = 3'd0;
					shreg = CMD_ADDR;
					ph = PH_S_CLKH;
				end else begin
					ph = PH_IDLE;
				end
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	function automatic line_word_t predict_word(input logic [1:0] op, input logic [23:0] data);
		line_word_t w;
		int v;
		logic [3:0] br;
		logic [7:0] code;
		w.accepted = 1'b0;
		case (op)
			OP_TICK: step_lines();
			OP_DECIMAL, OP_BRIGHT: begin
				// commands are only taken while the sequencer is idle
				if (ph == PH_IDLE) begin
					w.accepted = 1'b1;
					bit_cnt = 3'd0;
					byte_idx = 3'd0;
					frame_idx = 2'd0;
					wait_cnt = 16'd0;
					if (op == OP_DECIMAL) begin
						kind = KIND_DECIMAL;
						v = int'(data[VAL_W-1:0]);
						for (int i = 0; i < 4; i++) begin
							code = SEG_MAP[v % 10];
							if (i == 2 && data[14])
								code = code | SEP_BIT;
							digits[i] = code;
							v = v / 10;
						end
						shreg = CMD_DATA;
					end else begin
						kind = KIND_BRIGHT;
						br = data[18:15];
						if (br > BRIGHT_MAX)
							br = BRIGHT_MAX;
						shreg = CMD_DISP + 8'(br);
					end
					ph = PH_S_CLKH;
				end
			end
			default: ;
		endcase
		w.clk = clk_o;
		w.dio = dio_o;
		w.busy = (ph != PH_IDLE);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_word_t got, want;
		if (!arst_n) begin
			levels_q.delete();
			err_count = 0;
			ph = PH_IDLE;
			bit_cnt = 3'd0;
			byte_idx = 3'd0;
			frame_idx = 2'd0;
			kind = KIND_BRIGHT;
			wait_cnt = 16'd0;
			shreg = 8'd0;
			for (int i = 0; i < 4; i++)
				digits[i] = 8'd0;
			clk_o = 1'b1;
			dio_o = 1'b1;
			tpu = TPU_RESET;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = line_word_t'(m_axis_tdata[3:0]);
				if (levels_q.size() == 0) begin
					err_count++;
					$display("%0t: result word with nothing expected, actual tdata %h",
						$time, m_axis_tdata);
				end else begin
					want = levels_q.pop_front();
					if (m_axis_tdata !== {4'd0, want}) begin
						err_count++;
						$display({"%0t: line word mismatch: expected clk %0b dio %0b busy %0b ",
							"accepted %0b, actual clk %0b dio %0b busy %0b accepted %0b pad %h"},
							$time, want.clk, want.dio, want.busy, want.accepted,
							got.clk, got.dio, got.busy, got.accepted, m_axis_tdata[7:4]);
					end
				end
			end
			if (psel && penable && pready && paddr[2] == REG_TPU) begin
				if (pwrite) begin
					tpu = pwdata[TPU_W-1:0];
				end else if (prdata !== 32'(tpu)) begin
					err_count++;
					$display("%0t: register read mismatch: expected %h, actual %h",
						$time, 32'(tpu), prdata);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				levels_q.push_back(predict_word(s_axis_tuser, s_axis_tdata));
		end
		// registered copies so the stimulus side reads them without racing this block
		seq_busy <= (ph != PH_IDLE);
		words_in_flight <= levels_q.size();
	end

endmodule

// ===== verif/seven_segment_two_wire_driver_core_tb.sv =====
// testbench top for the two-wire seven-segment driver: clock, reset, stimulus and verdict
// drives command and tick words plus register writes and reads; checking lives in sstw_line_checker
// depends on sstw_pkg, seven_segment_two_wire_driver_core and sstw_line_checker
module seven_segment_two_wire_driver_core_tb;
	import sstw_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] TPU_ADDR = {REG_TPU, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // value[13:0], separator[14], brightness[18:15]
	logic [1:0]  s_axis_tuser;   // opcode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // clk_level[0], dio_level[1], busy_res[2], accepted[3]

	int   fail_count;
	int   words_in_flight;
	logic seq_busy;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int hold_left;

	seven_segment_two_wire_driver_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sstw_line_checker line_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.fail_count      (fail_count),
		.words_in_flight (words_in_flight),
		.seq_busy        (seq_busy)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, plus a long hold-off when one is requested
	initial begin
		m_axis_tready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// called at a rising edge; returns at the edge where the word is taken
	task automatic offer_word(input logic [1:0] op, input logic [13:0] val,
			input logic sep, input logic [3:0] br);
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'd0, br, sep, val};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic tick_word();
		offer_word(OP_TICK, 14'($urandom), 1'($urandom), 4'($urandom));
	endtask

	task automatic noise_word(input logic [1:0] op);
		offer_word(op, 14'($urandom), 1'($urandom), 4'($urandom));
	endtask

	// ticks until the line sequence is done; seq_busy lags one word, so always tick once
	task automatic drain_sequence(output int sent);
		sent = 1;
		tick_word();
		while (seq_busy) begin
			tick_word();
			sent++;
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	// setup and access phases, then psel and penable drop before the next transfer
	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= TPU_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_tpu(input logic [TPU_W-1:0] tpu);
		apb_access(1'b1, {22'($urandom), tpu});
		apb_access(1'b0, 32'd0);
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct, input int quota);
		int sent;
		logic [1:0] op;
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 85) begin
				op = ($urandom_range(2) == 0) ? OP_DECIMAL : OP_BRIGHT;
				noise_word(op);
				tick_word();
				sent += 2;
				// mostly ticks, now and then a command or unused-opcode word; the block turns commands down while busy
				while (seq_busy) begin
					if ($urandom_range(99) < 4)
						noise_word(2'($urandom_range(1, 3)));
					else
						tick_word();
					sent++;
				end
			end else begin
				noise_word(2'($urandom_range(0, 3)));
				sent++;
			end
		end
	endtask

	initial begin
		int n;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_TICK;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value, then the fastest line timing for the directed commands
		apb_access(1'b0, 32'd0);
		set_tpu(10'd0);

		offer_word(OP_TICK, 14'h3fff, 1'b1, 4'hf);
		offer_word(OP_UNUSED, 14'd1234, 1'b1, 4'd3);
		offer_word(OP_BRIGHT, 14'd0, 1'b0, 4'hf);
		offer_word(OP_DECIMAL, 14'd5678, 1'b1, 4'd0);
		offer_word(OP_BRIGHT, 14'd0, 1'b0, 4'd4);
		offer_word(OP_UNUSED, 14'd0, 1'b0, 4'd0);
		drain_sequence(n);

		// long hold-off on the result side while ticks keep coming
		offer_word(OP_BRIGHT, 14'h3fff, 1'b1, 4'd0);
		hold_req = 300;
		drain_sequence(n);

		offer_word(OP_DECIMAL, 14'd9999, 1'b1, 4'd0);
		drain_sequence(n);
		offer_word(OP_DECIMAL, 14'h3fff, 1'b0, 4'hf);
		drain_sequence(n);
		offer_word(OP_BRIGHT, 14'd9999, 1'b1, 4'd8);
		drain_sequence(n);
		settle();

		// slowest timing, then shorten it while the start wait is running
		set_tpu(10'd1023);
		offer_word(OP_BRIGHT, 14'd0, 1'b0, 4'd1);
		repeat (150) tick_word();
		settle();
		set_tpu(10'd1);
		drain_sequence(n);
		settle();

		set_tpu(10'd0);
		random_phase(0, 0, 80);
		drain_sequence(n);
		settle();
		random_phase(55, 0, 80);
		drain_sequence(n);
		settle();
		set_tpu(10'd1);
		random_phase(0, 55, 80);
		drain_sequence(n);
		settle();
		set_tpu(10'd0);
		random_phase(31, 31, 80);
		settle();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_in_flight == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sstw_pkg.sv
hdl/seven_segment_two_wire_driver_core.sv
verif/sstw_line_checker.sv
verif/seven_segment_two_wire_driver_core_tb.sv
